/* rtl/sha1sh_pkg.sv */
// sha1sh_pkg: shared types and constants of the SHA-1 stream hasher.
// Used by sha1sh_round, sha1sh_sched and sha1_stream_hasher_top.
package sha1sh_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} result_t;

	// working variables of the compression
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} work_t;

	typedef enum logic [1:0] {
		SCHED_HOLD,
		SCHED_LOAD,
		SCHED_ROUND
	} sched_op_t;

	typedef struct packed {
		sched_op_t op;
		logic      expand;
	} sched_ctrl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_RUN,
		S_ADD,
		S_EMIT
	} state_t;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [31:0] H_INIT [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [2:0] LAST_WORD  = 3'd4;

endpackage

/* rtl/sha1sh_round.sv */
// sha1sh_round: one SHA-1 round, shared by all 80 rounds of a block.
// Depends on sha1sh_pkg (work_t, round constants).
module sha1sh_round (
	input  sha1sh_pkg::work_t cur,
	input  logic [31:0]       x,
	input  logic [6:0]        rnd,
	output sha1sh_pkg::work_t nxt
);

	logic [31:0] f;
	logic [31:0] k;

	always_comb begin
		if (rnd < 7'd20) begin
			f = (cur.b & cur.c) | (~cur.b & cur.d);
			k = sha1sh_pkg::K0;
		end else if (rnd < 7'd40) begin
			f = cur.b ^ cur.c ^ cur.d;
			k = sha1sh_pkg::K1;
		end else if (rnd < 7'd60) begin
			f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
			k = sha1sh_pkg::K2;
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
			k = sha1sh_pkg::K3;
		end
	end

	assign nxt.a = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + x;
	assign nxt.b = cur.a;
	assign nxt.c = {cur.b[1:0], cur.b[31:2]};
	assign nxt.d = cur.c;
	assign nxt.e = cur.d;

endmodule

/* rtl/sha1sh_sched.sv */
// sha1sh_sched: 16-word message window as a shift line; loads message
// words and expands the schedule in place. Depends on sha1sh_pkg.
module sha1sh_sched (
	input  logic                    clk,
	input  sha1sh_pkg::sched_ctrl_t ctrl,
	input  logic [31:0]             word_in,
	output logic [31:0]             x
);

	logic [31:0] win_q [16];
	logic [31:0] mix;
	logic [31:0] push;

	// taps: w[i-3], w[i-8], w[i-14], w[i-16]
	assign mix  = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
	assign x    = ctrl.expand ? {mix[30:0], mix[31]} : win_q[0];
	assign push = (ctrl.op == sha1sh_pkg::SCHED_LOAD) ? word_in : x;

	always_ff @(posedge clk) begin
		if (ctrl.op != sha1sh_pkg::SCHED_HOLD) begin
			for (int j = 0; j < 15; j++) begin
				win_q[j] <= win_q[j+1];
			end
			win_q[15] <= push;
		end
	end

endmodule

/* rtl/sha1_stream_hasher_top.sv */
// sha1_stream_hasher_top: byte-stream SHA-1 with a sequencer around one shared round unit.
// A byte that completes a 64-byte block starts a compression of the block (80 rounds + add).
// A last beat pads one word per cycle and compresses once or twice, then offers the
// five digest words, one beat per cycle while result_stall is low.
// item_stall is high while a block compresses, pads or the digest is out.
// Reset (arst_n low) loads the initial chaining value and clears the byte count.
module sha1_stream_hasher_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  sha1sh_pkg::item_t   item,
	output logic                result_valid,
	input  logic                result_stall,
	output sha1sh_pkg::result_t result
);

	sha1sh_pkg::state_t      state_q, state_d;
	sha1sh_pkg::sched_ctrl_t sch;
	sha1sh_pkg::work_t       wk_q, wk_nxt, chain_w;

	logic [60:0] bc_q, bc_inc;
	logic [31:0] cur_q, cur_new, pad_lane, pad_word, word_in, x;
	logic [31:0] chain_q [5];
	logic [31:0] emit_word;
	logic [6:0]  rnd_q;
	logic [3:0]  wp_q;
	logic [2:0]  idx_q;
	logic [5:0]  pos, pos_nx;
	logic        fin_q, pad80_q, lenblk_q, done_q;
	logic        item_acc, byte_acc, blk_full, res_acc;

	assign item_acc = item_valid & ~item_stall;
	assign byte_acc = item_acc & item.has_byte;
	assign res_acc  = result_valid & ~result_stall;
	assign pos      = bc_q[5:0];
	assign bc_inc   = bc_q + 61'd1;
	assign pos_nx   = byte_acc ? bc_inc[5:0] : pos;
	assign blk_full = byte_acc && (pos == 6'd63);

	always_comb begin
		case (pos[1:0])
			2'd0:    cur_new = {item.data_byte, cur_q[23:0]};
			2'd1:    cur_new = {cur_q[31:24], item.data_byte, cur_q[15:0]};
			2'd2:    cur_new = {cur_q[31:16], item.data_byte, cur_q[7:0]};
			default: cur_new = {cur_q[31:8], item.data_byte};
		endcase
	end

	// word holding the pad byte: earlier bytes kept, later lanes zero
	always_comb begin
		case (bc_q[1:0])
			2'd0:    pad_lane = {sha1sh_pkg::PAD_BYTE, 24'h0};
			2'd1:    pad_lane = {cur_q[31:24], sha1sh_pkg::PAD_BYTE, 16'h0};
			2'd2:    pad_lane = {cur_q[31:16], sha1sh_pkg::PAD_BYTE, 8'h0};
			default: pad_lane = {cur_q[31:8], sha1sh_pkg::PAD_BYTE};
		endcase
	end

	always_comb begin
		if (pad80_q) begin
			pad_word = pad_lane;
		end else if (lenblk_q && wp_q == 4'd14) begin
			pad_word = bc_q[60:29];
		end else if (lenblk_q && wp_q == 4'd15) begin
			pad_word = {bc_q[28:0], 3'b000};
		end else begin
			pad_word = 32'h0;
		end
	end

	assign word_in = (state_q == sha1sh_pkg::S_PAD) ? pad_word : cur_new;

	assign chain_w = {chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};

	sha1sh_sched u_sched (
		.clk     (clk),
		.ctrl    (sch),
		.word_in (word_in),
		.x       (x)
	);

	sha1sh_round u_round (
		.cur (wk_q),
		.x   (x),
		.rnd (rnd_q),
		.nxt (wk_nxt)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sha1sh_pkg::S_IDLE: begin
				if (blk_full) begin
					state_d = sha1sh_pkg::S_RUN;
				end else if (item_acc && item.last) begin
					state_d = sha1sh_pkg::S_PAD;
				end
			end
			sha1sh_pkg::S_PAD: begin
				if (wp_q == 4'd15) begin
					state_d = sha1sh_pkg::S_RUN;
				end
			end
			sha1sh_pkg::S_RUN: begin
				if (rnd_q == sha1sh_pkg::LAST_ROUND) begin
					state_d = sha1sh_pkg::S_ADD;
				end
			end
			sha1sh_pkg::S_ADD: begin
				if (!fin_q) begin
					state_d = sha1sh_pkg::S_IDLE;
				end else if (done_q) begin
					state_d = sha1sh_pkg::S_EMIT;
				end else begin
					state_d = sha1sh_pkg::S_PAD;
				end
			end
			sha1sh_pkg::S_EMIT: begin
				if (res_acc && idx_q == sha1sh_pkg::LAST_WORD) begin
					state_d = sha1sh_pkg::S_IDLE;
				end
			end
			default: state_d = sha1sh_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item_stall   = 1'b1;
		result_valid = 1'b0;
		sch.op       = sha1sh_pkg::SCHED_HOLD;
		sch.expand   = 1'b0;
		unique case (state_q)
			sha1sh_pkg::S_IDLE: begin
				item_stall = 1'b0;
				if (byte_acc && pos[1:0] == 2'd3) begin
					sch.op = sha1sh_pkg::SCHED_LOAD;
				end
			end
			sha1sh_pkg::S_PAD: sch.op = sha1sh_pkg::SCHED_LOAD;
			sha1sh_pkg::S_RUN: begin
				sch.op     = sha1sh_pkg::SCHED_ROUND;
				sch.expand = (rnd_q >= 7'd16);
			end
			sha1sh_pkg::S_ADD: ;
			sha1sh_pkg::S_EMIT: result_valid = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		case (idx_q)
			3'd0:    emit_word = chain_q[0];
			3'd1:    emit_word = chain_q[1];
			3'd2:    emit_word = chain_q[2];
			3'd3:    emit_word = chain_q[3];
			default: emit_word = chain_q[4];
		endcase
	end

	assign result.digest_word = emit_word;
	assign result.word_index  = idx_q;
	assign result.last_word   = (idx_q == sha1sh_pkg::LAST_WORD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sha1sh_pkg::S_IDLE;
			bc_q     <= '0;
			rnd_q    <= '0;
			wp_q     <= '0;
			idx_q    <= '0;
			fin_q    <= 1'b0;
			pad80_q  <= 1'b0;
			lenblk_q <= 1'b0;
			done_q   <= 1'b0;
			for (int i = 0; i < 5; i++) begin
				chain_q[i] <= sha1sh_pkg::H_INIT[i];
			end
		end else begin
			state_q <= state_d;
			unique case (state_q)
				sha1sh_pkg::S_IDLE: begin
					if (byte_acc) begin
						bc_q <= bc_inc;
					end
					if (item_acc) begin
						fin_q    <= item.last;
						pad80_q  <= 1'b1;
						lenblk_q <= (pos_nx < 6'd56);
						done_q   <= 1'b0;
						wp_q     <= pos_nx[5:2];
					end
					rnd_q <= '0;
				end
				sha1sh_pkg::S_PAD: begin
					wp_q    <= wp_q + 4'd1;
					pad80_q <= 1'b0;
					rnd_q   <= '0;
					if (wp_q == 4'd15 && lenblk_q) begin
						done_q <= 1'b1;
					end
				end
				sha1sh_pkg::S_RUN: rnd_q <= rnd_q + 7'd1;
				sha1sh_pkg::S_ADD: begin
					chain_q[0] <= chain_q[0] + wk_q.a;
					chain_q[1] <= chain_q[1] + wk_q.b;
					chain_q[2] <= chain_q[2] + wk_q.c;
					chain_q[3] <= chain_q[3] + wk_q.d;
					chain_q[4] <= chain_q[4] + wk_q.e;
					lenblk_q   <= 1'b1;
				end
				sha1sh_pkg::S_EMIT: begin
					if (res_acc) begin
						if (idx_q == sha1sh_pkg::LAST_WORD) begin
							idx_q <= '0;
							bc_q  <= '0;
							for (int i = 0; i < 5; i++) begin
								chain_q[i] <= sha1sh_pkg::H_INIT[i];
							end
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (byte_acc) begin
			cur_q <= cur_new;
		end
		if (state_q == sha1sh_pkg::S_RUN) begin
			wk_q <= wk_nxt;
		end else begin
			wk_q <= chain_w;
		end
	end

	a_block_start: assert property (@(posedge clk) disable iff (!arst_n)
		blk_full |=> state_q == sha1sh_pkg::S_RUN && rnd_q == 7'd0)
		else $error("full block did not start compression");

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha1sh_pkg::S_RUN && rnd_q == sha1sh_pkg::LAST_ROUND)
		|=> state_q == sha1sh_pkg::S_ADD)
		else $error("compression did not end after round 79");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_acc && result.last_word) |=> state_q == sha1sh_pkg::S_IDLE && bc_q == 61'd0
		&& chain_q[0] == sha1sh_pkg::H_INIT[0])
		else $error("state not restored after final digest beat");

endmodule

/* sim/sha1_digest_checker.sv */
// sha1_digest_checker: watches the item and result channels of the SHA-1 stream hasher,
// predicts the digest words of each message and compares every result beat.
// Depends on sha1sh_pkg for the beat types and the SHA-1 constants.
`timescale 1ns / 1ps

module sha1_digest_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_stall,
	input  sha1sh_pkg::item_t   item,
	input  logic                result_valid,
	input  logic                result_stall,
	input  sha1sh_pkg::result_t result,
	output int                  mismatches,
	output int                  outstanding
);

	logic [31:0]         chain [5];
	logic [31:0]         window [16];
	logic [60:0]         nbytes;
	sha1sh_pkg::result_t digest_words_due [$];
	sha1sh_pkg::result_t got;
	sha1sh_pkg::result_t want;

	initial mismatches = 0;

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t ns: mismatch: %s", $time, what);
	endtask

	function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic void place_byte(input int unsigned pos, input logic [7:0] b);
		int unsigned sh;
		sh = 24 - 8 * (pos % 4);
		window[(pos / 4) % 16][sh +: 8] = b;
	endfunction

	function automatic void sha1_compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, k, t, x;
		int          i;
		w = window;
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		e = chain[4];
		for (i = 0; i < 80; i++) begin
			if (i < 16) begin
				x = w[i];
			end else begin
				x = rotl(w[(i - 3) & 15] ^ w[(i - 8) & 15] ^ w[(i - 14) & 15] ^ w[i & 15], 1);
				w[i & 15] = x;
			end
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = sha1sh_pkg::K0;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = sha1sh_pkg::K1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = sha1sh_pkg::K2;
			end else begin
				f = b ^ c ^ d;
				k = sha1sh_pkg::K3;
			end
			t = rotl(a, 5) + f + e + k + x;
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
		chain[4] += e;
	endfunction

	// take one accepted beat into the running hash; a last beat queues the five digest words
	function automatic void hash_item(input sha1sh_pkg::item_t it);
		int unsigned         pos;
		int unsigned         i;
		logic [63:0]         bitlen;
		sha1sh_pkg::result_t r;
		if (it.has_byte) begin
			pos = 32'(nbytes[5:0]);
			place_byte(pos, it.data_byte);
			nbytes = nbytes + 1'b1;
			if (pos == 63)
				sha1_compress();
		end
		if (!it.last)
			return;
		pos = 32'(nbytes[5:0]);
		bitlen = {nbytes, 3'b000};
		place_byte(pos, sha1sh_pkg::PAD_BYTE);
		for (i = pos + 1; i < 64; i++)
			place_byte(i, 8'h00);
		// no room left for the length: flush this block and pad a fresh one
		if (pos >= 56) begin
			sha1_compress();
			foreach (window[j])
				window[j] = '0;
		end
		window[14] = bitlen[63:32];
		window[15] = bitlen[31:0];
		sha1_compress();
		for (i = 0; i < 5; i++) begin
			r.digest_word = chain[i];
			r.word_index = i[2:0];
			r.last_word = (i[2:0] == sha1sh_pkg::LAST_WORD);
			digest_words_due.push_back(r);
		end
		chain = sha1sh_pkg::H_INIT;
		nbytes = '0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain = sha1sh_pkg::H_INIT;
			foreach (window[j])
				window[j] = '0;
			nbytes = '0;
			digest_words_due.delete();
			outstanding <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				got = result;
				if (digest_words_due.size() == 0) begin
					report_mismatch($sformatf("result beat %h with no digest word due", got));
				end else begin
					want = digest_words_due.pop_front();
					if (got.digest_word !== want.digest_word)
						report_mismatch($sformatf("H%0d: digest_word %h, expected %h",
							want.word_index, got.digest_word, want.digest_word));
					if (got.word_index !== want.word_index)
						report_mismatch($sformatf("word_index %0d, expected %0d",
							got.word_index, want.word_index));
					if (got.last_word !== want.last_word)
						report_mismatch($sformatf("H%0d: last_word %b, expected %b",
							want.word_index, got.last_word, want.last_word));
				end
			end
			if (item_valid && !item_stall)
				hash_item(item);
			outstanding <= digest_words_due.size();
		end
	end

endmodule

/* sim/sha1_stream_hasher_top_tb.sv */
// sha1_stream_hasher_top_tb: drives byte-stream messages into the SHA-1 hasher under
// several idling patterns and gives the verdict. Depends on sha1sh_pkg, the RTL top
// and sha1_digest_checker, which predicts and compares the digest words.
`timescale 1ns / 1ps

module sha1_stream_hasher_top_tb;

	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 300;
	localparam int PHASE_ITEMS  = 66;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_stall;
	sha1sh_pkg::item_t   item         = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	sha1sh_pkg::result_t result;

	int   fail_count;
	int   pending;
	int   idle_pct      = 0;
	int   stall_pct     = 0;
	logic hold_go       = 1'b0;
	logic hold_on       = 1'b0;
	int   msg_items     = 0;
	int   messages_sent = 0;

	int   phase_idle  [4] = '{0, 81, 0, 10};
	int   phase_stall [4] = '{0, 0, 81, 10};
	int   phase_len   [4] = '{64, 55, 56, 63};
	bit   phase_split [4] = '{1'b1, 1'b0, 1'b1, 1'b0};

	always #5 clk = ~clk;

	sha1_stream_hasher_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	sha1_digest_checker digest_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.mismatches   (fail_count),
		.outstanding  (pending)
	);

	always @(posedge clk) begin
		result_stall <= hold_on || ($urandom_range(0, 99) < stall_pct);
	end

	// long receiver hold-off so the digest backs up and the block stalls its input
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d digest words still due", pending);
		$display("FAIL sha1_stream_hasher_top");
		$finish;
	end

	function automatic sha1sh_pkg::item_t mk_item(input logic [7:0] d, input logic hb,
		input logic lst);
		sha1sh_pkg::item_t it;
		it.data_byte = d;
		it.has_byte = hb;
		it.last = lst;
		return it;
	endfunction

	task automatic put_beat(input sha1sh_pkg::item_t it);
		while ($urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	// one message of len random bytes; split_end closes it with a separate empty last beat
	task automatic send_message(input int len, input bit split_end);
		int n;
		bit split;
		split = split_end || (len == 0);
		for (n = 0; n < len; n++) begin
			if ($urandom_range(0, 99) < 6)
				put_beat(mk_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
			put_beat(mk_item(8'($urandom_range(0, 255)), 1'b1, !split && n == len - 1));
			msg_items++;
		end
		if (split) begin
			put_beat(mk_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
			msg_items++;
		end
		messages_sent++;
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic int pick_length();
		int sel;
		int edges [5] = '{55, 56, 63, 64, 65};
		sel = $urandom_range(0, 9);
		if (sel <= 6)
			return $urandom_range(0, 12);
		else if (sel <= 8)
			return edges[$urandom_range(0, 4)];
		return $urandom_range(13, 40);
	endfunction

	initial begin
		int ph;
		int start;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty messages, one-byte messages at both extremes, ignored beats, split ends
		put_beat(mk_item(8'hFF, 1'b0, 1'b1));
		put_beat(mk_item(8'hA5, 1'b0, 1'b0));
		put_beat(mk_item(8'h00, 1'b1, 1'b1));
		put_beat(mk_item(8'hFF, 1'b1, 1'b1));
		put_beat(mk_item(8'h5A, 1'b0, 1'b1));
		put_beat(mk_item(8'h61, 1'b1, 1'b0));
		put_beat(mk_item(8'h62, 1'b1, 1'b0));
		put_beat(mk_item(8'h63, 1'b1, 1'b1));
		put_beat(mk_item(8'h00, 1'b0, 1'b0));
		put_beat(mk_item(8'h80, 1'b1, 1'b0));
		put_beat(mk_item(8'h7F, 1'b0, 1'b1));
		put_beat(mk_item(8'h01, 1'b1, 1'b0));
		put_beat(mk_item(8'hFE, 1'b1, 1'b0));
		put_beat(mk_item(8'h55, 1'b0, 1'b0));
		put_beat(mk_item(8'hAA, 1'b1, 1'b1));
		wait_drained();

		for (ph = 0; ph < 4; ph++) begin
			idle_pct = phase_idle[ph];
			stall_pct <= phase_stall[ph];
			if (ph == 0)
				hold_go = 1'b1;
			start = msg_items;
			// each phase opens on a block-boundary length, then random messages
			send_message(phase_len[ph], phase_split[ph]);
			while (msg_items - start < PHASE_ITEMS)
				send_message(pick_length(), $urandom_range(0, 2) == 0);
			wait_drained();
		end
		stall_pct <= 0;
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d messages, %0d message beats, under four idling patterns",
			messages_sent, msg_items);
		$display("with block-boundary lengths, empty messages and a long receiver hold-off");
		if (fail_count == 0 && pending == 0) begin
			$display("PASS sha1_stream_hasher_top");
		end else begin
			$display("%0d mismatches, %0d digest words never arrived", fail_count, pending);
			$display("FAIL sha1_stream_hasher_top");
		end
		$finish;
	end

endmodule
